@@ rtl/core/swk_pkg.sv @@
package swk_pkg;

	// One wheel request
	typedef struct packed {
		logic signed [15:0] translation_x;
		logic signed [15:0] translation_y;
		logic signed [15:0] yaw_rate;
		logic [15:0]        heading_angle;
		logic signed [15:0] wheel_offset_x;
		logic signed [15:0] wheel_offset_y;
		logic [15:0]        wheel_diameter;
		logic               last_wheel;
	} item_t;

	// One wheel command
	typedef struct packed {
		logic [15:0]        wheel_spin_rate;
		logic [15:0]        wheel_spin_accel;
		logic [15:0]        steer_angle;
		logic signed [15:0] steer_rate;
		logic               zero_speed;
		logic               last_out;
	} result_t;

	localparam int ITERS     = 20;
	localparam int GAIN_Q16  = 39797;
	// front: entry, ITERS rotations, gain, two multiply stages
	localparam int FR_STAGES = ITERS + 4;
	// back: accel/init, 3 product stages, 32 sqrt, mul, div init, 16 div
	localparam int BK_STAGES = 54;
	localparam int LATENCY   = FR_STAGES + BK_STAGES + 1;

	// atan(2^-i) in 2^32 binary angle units
	function automatic logic [31:0] atan_entry(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/core/swerve_wheel_kinematics_core.sv @@
// Swerve wheel inverse kinematics, one wheel per transfer.
// Input: raise start with a wheel request on item; it is taken at any clock
// edge with start high and busy low. busy stays low: a new wheel can enter
// every cycle.
// Output: done is high for one cycle with the wheel command on result, once the
// transfer has passed the front and back pipelines and the output register.
// There is no back pressure; the receiver must take each result in that cycle.
// Throughput is one wheel per clock, set by the fully pipelined datapath:
// 20-stage CORDIC rotation of the mount offset, velocity and acceleration
// multipliers, 64-bit products split into 32-bit partials, a 32-stage square
// root with the 20-stage CORDIC atan2 beside it, and 16 restoring divide
// stages for spin rate, spin acceleration and steering rate.
// Configuration: cfg_wr_en writes cfg_wr_data into the heading trim. Write it
// only while no wheel is in flight.
// Reset (arst_n low) clears the trim and all stage valid bits; items in
// flight are dropped and no result is shown until a new transfer.
module swerve_wheel_kinematics_core import swk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	output logic        done,
	output result_t     result
);

	localparam int RW = 36;   // rotated offset
	localparam int ZW = 34;   // CORDIC angle accumulator
	localparam int MW = 52;   // w * P
	localparam int VW = 42;   // velocity
	localparam int QW = 68;   // w * w * P
	localparam int AW = 46;   // acceleration
	localparam int CW = 56;   // atan2 CORDIC vector

	typedef struct packed {
		logic signed [15:0] tx;
		logic signed [15:0] ty;
		logic signed [15:0] w;
		logic [15:0]        d;
		logic [15:0]        ang;
		logic               last;
	} carry_t;

	typedef struct packed {
		carry_t             c;
		logic signed [RW-1:0] x;
		logic signed [RW-1:0] y;
		logic signed [ZW-1:0] z;
		logic signed [RW-1:0] px;
		logic signed [RW-1:0] py;
		logic signed [MW-1:0] pxw;
		logic signed [MW-1:0] pyw;
		logic signed [VW-1:0] vx;
		logic signed [VW-1:0] vy;
		logic signed [QW-1:0] pxww;
		logic signed [QW-1:0] pyww;
	} fr_t;

	// low 64 bits of a product as two partials
	typedef struct packed {
		logic [63:0] lo;
		logic [31:0] mid;
	} mp_t;

	typedef struct packed {
		logic [15:0]          ang;
		logic [15:0]          d;
		logic                 last;
		logic                 zero;
		logic signed [VW-1:0] vx;
		logic signed [VW-1:0] vy;
		logic signed [AW-1:0] ax;
		logic signed [AW-1:0] ay;
		mp_t                  m_xx;
		mp_t                  m_yy;
		mp_t                  m_ax;
		mp_t                  m_ay;
		mp_t                  m_cx;
		mp_t                  m_cy;
		logic [63:0]          p_xx;
		logic [63:0]          p_yy;
		logic [63:0]          p_ax;
		logic [63:0]          p_ay;
		logic [63:0]          p_cx;
		logic [63:0]          p_cy;
		logic [63:0]          s;
		logic [63:0]          adot;
		logic [63:0]          acr;
		logic                 crneg;
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic signed [ZW-1:0] cz;
		logic [63:0]          n;
		logic [63:0]          r;
		logic [47:0]          dd;
		logic                 sat_s;
		logic                 sat_a;
		logic                 sat_r;
		logic [32:0]          rs;
		logic [63:0]          ra;
		logic [63:0]          rr;
		logic [15:0]          qs;
		logic [15:0]          qa;
		logic [14:0]          qr;
	} bk_t;

	logic [15:0] trim_q;
	fr_t         fr_s  [FR_STAGES];
	logic        frv_s [FR_STAGES];
	bk_t         bk_s  [BK_STAGES];
	logic        bkv_s [BK_STAGES];
	logic        done_q;
	result_t     result_q;

	function automatic mp_t mulp(input logic [63:0] a, input logic [63:0] b);
		mp_t o;
		o.lo  = {32'b0, a[31:0]} * {32'b0, b[31:0]};
		o.mid = a[63:32] * b[31:0] + a[31:0] * b[63:32];
		return o;
	endfunction

	function automatic logic [63:0] mpsum(input mp_t m);
		return m.lo + {m.mid, 32'b0};
	endfunction

	// entry: offset to 2^-24 m, fold the heading into quadrants 0 and 3
	function automatic fr_t f_entry(input item_t it, input logic [15:0] trim);
		fr_t o;
		logic [31:0] a;
		o = '0;
		o.c.tx   = it.translation_x;
		o.c.ty   = it.translation_y;
		o.c.w    = it.yaw_rate;
		o.c.d    = it.wheel_diameter;
		o.c.ang  = it.heading_angle + trim;
		o.c.last = it.last_wheel;
		o.x = RW'(it.wheel_offset_x) <<< 16;
		o.y = RW'(it.wheel_offset_y) <<< 16;
		a = {it.heading_angle, 16'b0};
		if (a[31] != a[30]) begin
			o.x = -o.x;
			o.y = -o.y;
			a[31] = ~a[31];
		end
		o.z = ZW'($signed(a));
		return o;
	endfunction

	// front stages: rotation, gain, velocity and w^2 products
	function automatic fr_t f_front(input fr_t f, input int g);
		fr_t o;
		logic signed [RW-1:0] dx;
		logic signed [RW-1:0] dy;
		logic signed [ZW-1:0] at;
		logic signed [RW+16:0] gx;
		logic signed [RW+16:0] gy;
		logic signed [MW-1:0] rx;
		logic signed [MW-1:0] ry;
		o = f;
		if (g <= ITERS) begin
			dx = f.y >>> (g - 1);
			dy = f.x >>> (g - 1);
			at = $signed({2'b00, atan_entry(5'(g - 1))});
			if (!f.z[ZW-1]) begin
				o.x = f.x - dx;
				o.y = f.y + dy;
				o.z = f.z - at;
			end else begin
				o.x = f.x + dx;
				o.y = f.y - dy;
				o.z = f.z + at;
			end
		end else if (g == ITERS + 1) begin
			gx = f.x * $signed({1'b0, 16'(GAIN_Q16)});
			gy = f.y * $signed({1'b0, 16'(GAIN_Q16)});
			gx = gx + 53'sd8388608;
			gy = gy + 53'sd8388608;
			o.px = RW'(gx >>> 24);
			o.py = RW'(gy >>> 24);
		end else if (g == ITERS + 2) begin
			o.pxw = f.c.w * f.px;
			o.pyw = f.c.w * f.py;
		end else begin
			rx = (f.pxw + 52'sd2048) >>> 12;
			ry = (f.pyw + 52'sd2048) >>> 12;
			o.vx = (VW'(f.c.tx) <<< 8) - VW'(ry);
			o.vy = (VW'(f.c.ty) <<< 8) + VW'(rx);
			o.pxww = f.pxw * f.c.w;
			o.pyww = f.pyw * f.c.w;
		end
		return o;
	endfunction

	// acceleration, zero test, atan2 vector setup
	function automatic bk_t f_accel(input fr_t f);
		bk_t o;
		logic signed [QW-1:0] tx;
		logic signed [QW-1:0] ty;
		o = '0;
		o.ang  = f.c.ang;
		o.d    = f.c.d;
		o.last = f.c.last;
		o.vx   = f.vx;
		o.vy   = f.vy;
		tx = (f.pxww + 68'sd8388608) >>> 24;
		ty = (f.pyww + 68'sd8388608) >>> 24;
		o.ax = -AW'(tx);
		o.ay = -AW'(ty);
		o.zero = (f.vx == '0) && (f.vy == '0);
		o.cx = CW'(f.vy) <<< 12;
		o.cy = CW'(f.vx) <<< 12;
		o.cz = '0;
		if (o.cx[CW-1]) begin
			o.cx = -o.cx;
			o.cy = -o.cy;
			o.cz = 34'sd2147483648;
		end
		return o;
	endfunction

	// back stages: products, square root with atan2, dividers
	function automatic bk_t f_back(input bk_t b, input int g);
		bk_t o;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [ZW-1:0] at;
		logic [63:0] bit_v;
		logic [64:0] sum;
		logic [63:0] dot;
		logic [63:0] cr;
		logic [32:0] ts;
		logic [63:0] ta;
		logic [70:0] tr;
		int k;
		int i;
		int sh;
		o = b;
		if (g == 1) begin
			o.m_xx = mulp(64'(b.vx), 64'(b.vx));
			o.m_yy = mulp(64'(b.vy), 64'(b.vy));
			o.m_ax = mulp(64'(b.ax), 64'(b.vx));
			o.m_ay = mulp(64'(b.ay), 64'(b.vy));
			o.m_cx = mulp(64'(b.vx), 64'(b.ay));
			o.m_cy = mulp(64'(b.vy), 64'(b.ax));
		end else if (g == 2) begin
			o.p_xx = mpsum(b.m_xx);
			o.p_yy = mpsum(b.m_yy);
			o.p_ax = mpsum(b.m_ax);
			o.p_ay = mpsum(b.m_ay);
			o.p_cx = mpsum(b.m_cx);
			o.p_cy = mpsum(b.m_cy);
		end else if (g == 3) begin
			o.s = b.p_xx + b.p_yy;
			dot = b.p_ax + b.p_ay;
			cr  = b.p_cx - b.p_cy;
			o.adot  = dot[63] ? (64'd0 - dot) : dot;
			o.acr   = cr[63] ? (64'd0 - cr) : cr;
			o.crneg = cr[63];
			o.n = o.s;
			o.r = '0;
		end else if (g <= 35) begin
			// one result bit of the square root per stage
			k = g - 4;
			bit_v = 64'd1 << (62 - 2 * k);
			sum = {1'b0, b.r} + {1'b0, bit_v};
			if ({1'b0, b.n} >= sum) begin
				o.n = b.n - sum[63:0];
				o.r = (b.r >> 1) + bit_v;
			end else begin
				o.r = b.r >> 1;
			end
			// atan2 vectoring step alongside
			if (k < ITERS) begin
				dx = b.cy >>> k;
				dy = b.cx >>> k;
				at = $signed({2'b00, atan_entry(5'(k))});
				if (!b.cy[CW-1]) begin
					o.cx = b.cx + dx;
					o.cy = b.cy - dy;
					o.cz = b.cz + at;
				end else begin
					o.cx = b.cx - dx;
					o.cy = b.cy + dy;
					o.cz = b.cz - at;
				end
			end
		end else if (g == 36) begin
			// spin numerators are twice the speed terms
			o.dd = {16'b0, b.r[31:0]} * {32'b0, b.d};
			o.rs = {b.r[31:0], 1'b0};
			o.ra = {b.adot[62:0], 1'b0};
			o.rr = b.acr;
		end else if (g == 37) begin
			o.sat_s = b.rs >= {1'b0, b.d, 16'b0};
			o.sat_a = {1'b0, b.ra} >= {1'b0, b.dd, 16'b0};
			o.sat_r = {7'b0, b.acr} >= {b.s, 7'b0};
			o.qs = '0;
			o.qa = '0;
			o.qr = '0;
		end else begin
			// restoring divide, one quotient bit per stage
			k = g - 38;
			i = 15 - k;
			ts = 33'(b.d) << i;
			if (b.rs >= ts) begin
				o.rs = b.rs - ts;
				o.qs[i] = 1'b1;
			end
			ta = {16'b0, b.dd} << i;
			if (b.ra >= ta) begin
				o.ra = b.ra - ta;
				o.qa[i] = 1'b1;
			end
			if (k < 15) begin
				// integer part first, then remainder * 256 for the fraction
				if (k == 7) o.rr = b.rr << 8;
				sh = (k < 7) ? (6 - k) : (14 - k);
				tr = {7'b0, b.s} << sh;
				if ({7'b0, o.rr} >= tr) begin
					o.rr = o.rr - tr[63:0];
					o.qr[14-k] = 1'b1;
				end
			end
		end
		return o;
	endfunction

	function automatic result_t f_result(input bk_t b);
		result_t o;
		logic signed [ZW-1:0] zr;
		logic [15:0] mag;
		zr  = b.cz + 34'sd32768;
		mag = b.sat_r ? (b.crneg ? 16'd32768 : 16'd32767) : {1'b0, b.qr};
		o.zero_speed = b.zero;
		o.last_out   = b.last;
		if (b.zero) begin
			o.wheel_spin_rate  = '0;
			o.wheel_spin_accel = '0;
			o.steer_rate       = '0;
			o.steer_angle      = b.ang;
		end else begin
			o.wheel_spin_rate  = b.sat_s ? 16'hFFFF : b.qs;
			o.wheel_spin_accel = b.sat_a ? 16'hFFFF : b.qa;
			o.steer_rate       = b.crneg ? $signed(16'd0 - mag) : $signed(mag);
			o.steer_angle      = b.ang + zr[31:16];
		end
		return o;
	endfunction

	assign busy = 1'b0;

	// heading trim register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trim_q <= '0;
		end else if (cfg_wr_en) begin
			trim_q <= cfg_wr_data;
		end
	end

	// entry stage
	always_ff @(posedge clk) begin
		fr_s[0] <= f_entry(item, trim_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frv_s[0] <= 1'b0;
		end else begin
			frv_s[0] <= start && !busy;
		end
	end

	// front pipeline
	for (genvar g = 1; g < FR_STAGES; g++) begin : g_front
		always_ff @(posedge clk) begin
			fr_s[g] <= f_front(fr_s[g-1], g);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				frv_s[g] <= 1'b0;
			end else begin
				frv_s[g] <= frv_s[g-1];
			end
		end
	end

	// hand-off into the back pipeline
	always_ff @(posedge clk) begin
		bk_s[0] <= f_accel(fr_s[FR_STAGES-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bkv_s[0] <= 1'b0;
		end else begin
			bkv_s[0] <= frv_s[FR_STAGES-1];
		end
	end

	// back pipeline
	for (genvar g = 1; g < BK_STAGES; g++) begin : g_back
		always_ff @(posedge clk) begin
			bk_s[g] <= f_back(bk_s[g-1], g);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				bkv_s[g] <= 1'b0;
			end else begin
				bkv_s[g] <= bkv_s[g-1];
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		result_q <= f_result(bk_s[BK_STAGES-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= bkv_s[BK_STAGES-1];
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ rtl/core/swk_checker.sv @@
module swk_checker import swk_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input item_t   item,
	input logic    done,
	input result_t result
);

	// every result traces back to a transfer a fixed latency earlier
	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching input transfer");

	// the last-wheel marker follows its own wheel
	a_last_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.last_out == $past(item.last_wheel, LATENCY))
		else $error("last_out does not match its wheel");

	// standing wheel reports no rates
	a_zero_rates: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.zero_speed |-> result.wheel_spin_rate == 16'd0 &&
			result.wheel_spin_accel == 16'd0 && result.steer_rate == 16'sd0)
		else $error("rates nonzero at zero speed");

	// zero diameter on a moving wheel saturates the spin outputs
	a_zero_diam: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.zero_speed && $past(item.wheel_diameter, LATENCY) == 16'd0
		|-> result.wheel_spin_rate == 16'hFFFF && result.wheel_spin_accel == 16'hFFFF)
		else $error("spin not saturated for zero diameter");

endmodule

bind swerve_wheel_kinematics_core swk_checker u_swk_checker (.*);
